// ----- hdl/quoted_field_tokenizer_top_defines.svh -----
// ---------------------------------------------------------------------------
// Assertion macros for the quoted field tokenizer
// Shared property templates; every check is clocked on clock and held off
// while reset is high.
// ---------------------------------------------------------------------------
`ifndef QUOTED_FIELD_TOKENIZER_TOP_DEFINES_SVH
`define QUOTED_FIELD_TOKENIZER_TOP_DEFINES_SVH

// Same-cycle implication.
`define QFT_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) \
      (ante) |-> (cons)) else $error(msg);

// Implication checked in the cycle after the antecedent.
`define QFT_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) \
      (ante) |=> (cons)) else $error(msg);

`endif

// ----- hdl/qft_pkg.sv -----
// ---------------------------------------------------------------------------
// qft_pkg
// Types and constants shared by the quoted field tokenizer modules.
// ---------------------------------------------------------------------------
`default_nettype none

package qft_pkg;

   // Character codes
   localparam logic [7:0] CHAR_NUL    = 8'h00;
   localparam logic [7:0] CHAR_TAB    = 8'h09;
   localparam logic [7:0] CHAR_LF     = 8'h0A;
   localparam logic [7:0] CHAR_SPACE  = 8'h20;
   localparam logic [7:0] CHAR_DQUOTE = 8'h22;
   localparam logic [7:0] CHAR_SQUOTE = 8'h27;

   // Register map
   localparam int         CSR_ADDR_W    = 3;
   localparam logic       REG_EXTRA_SEP = 1'b0;
   localparam logic [7:0] SEP_RESET     = CHAR_SPACE;

   typedef enum logic [1:0] {
      MODE_BETWEEN,
      MODE_TOKEN,
      MODE_QUOTED,
      MODE_DISCARD
   } mode_type;

   typedef enum logic [1:0] {
      KIND_CHAR,
      KIND_END,
      KIND_LINE
   } kind_type;

   typedef struct packed {
      kind_type   kind;
      logic [7:0] payload;
      logic [4:0] token_number;
      logic       last;
   } rsp_item_type;

   // Results of one item as handed to the result queue.
   typedef struct packed {
      logic [1:0]   count;
      rsp_item_type item0;
      rsp_item_type item1;
   } scan_out_type;

   function automatic logic is_eol(input logic [7:0] c);
      return (c == CHAR_NUL) || (c == CHAR_LF);
   endfunction

   function automatic logic is_quote(input logic [7:0] c);
      return (c == CHAR_SQUOTE) || (c == CHAR_DQUOTE);
   endfunction

   function automatic logic is_sep(input logic [7:0] c, input logic [7:0] extra);
      return (c == CHAR_SPACE) || (c == CHAR_TAB) || (c == extra);
   endfunction

endpackage

`default_nettype wire

// ----- hdl/qft_csr.sv -----
// ---------------------------------------------------------------------------
// qft_csr
// APB-style register port holding the extra separator character.
// ---------------------------------------------------------------------------
`default_nettype none

module qft_csr import qft_pkg::*; (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  csr_psel,
   input  wire logic                  csr_penable,
   input  wire logic                  csr_pwrite,
   input  wire logic [CSR_ADDR_W-1:0] csr_paddr,
   input  wire logic [31:0]           csr_pwdata,
   output logic      [31:0]           csr_prdata,
   output logic                       csr_pready,
   output logic      [7:0]            extra_sep
);

   logic [7:0] sep_ff;
   logic [7:0] sep_in;
   logic       reg_hit;

   assign reg_hit    = (csr_paddr[CSR_ADDR_W-1] == REG_EXTRA_SEP);
   assign csr_pready = 1'b1;

   always_comb begin
      sep_in = sep_ff;
      if (csr_psel && csr_penable && csr_pwrite && reg_hit) begin
         sep_in = csr_pwdata[7:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sep_ff <= SEP_RESET;
      end else begin
         sep_ff <= sep_in;
      end
   end

   assign csr_prdata = reg_hit ? {24'd0, sep_ff} : 32'd0;
   assign extra_sep  = sep_ff;

endmodule

`default_nettype wire

// ----- hdl/qft_scan.sv -----
// ---------------------------------------------------------------------------
// qft_scan
// Input register and the per-character scan logic with its mode and count.
// ---------------------------------------------------------------------------
`default_nettype none

`include "quoted_field_tokenizer_top_defines.svh"

module qft_scan import qft_pkg::*; #(
   parameter int MAX_PARAMS = 32
) (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_ready,
   input  wire logic [7:0] req_text_char,
   input  wire logic [7:0] extra_sep,
   input  wire logic       room,
   output scan_out_type    scan_out
);

   localparam int           CW      = $clog2(MAX_PARAMS);
   localparam logic [CW-1:0] CNT_MAX = CW'(MAX_PARAMS - 1);

   logic          in_valid_ff, in_valid_in;
   logic [7:0]    in_char_ff;
   mode_type      mode_ff, mode_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic          fire;
   logic [CW-1:0] cur;
   logic [CW+7:0] cnt_ext;
   logic [CW+7:0] cur_ext;
   logic [7:0]    line_count;
   rsp_item_type  line_item;
   rsp_item_type  item0, item1;
   logic [1:0]    nres;
   logic [7:0]    c;

   assign fire      = in_valid_ff && room;
   assign req_ready = !in_valid_ff || room;
   assign c         = in_char_ff;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_valid && req_ready) begin
         in_valid_in = 1'b1;
      end else if (fire) begin
         in_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_char_ff <= req_text_char;
      end
   end

   // Index of the parameter currently open, and the line-end result.
   assign cur        = (cnt_ff == '0) ? '0 : cnt_ff - CW'(1);
   assign cnt_ext    = {8'd0, cnt_ff};
   assign cur_ext    = {8'd0, cur};
   assign line_count = (cnt_ff == '0) ? 8'd1 : cnt_ext[7:0];

   always_comb begin
      line_item.kind         = KIND_LINE;
      line_item.payload      = line_count;
      line_item.token_number = cnt_ext[4:0];
      line_item.last         = 1'b1;
   end

   always_comb begin
      mode_in = mode_ff;
      cnt_in  = cnt_ff;
      nres    = 2'd0;
      item0   = line_item;
      item1   = line_item;
      unique case (mode_ff)
         MODE_BETWEEN: begin
            // NUL ends the line even when it is the extra separator, while a
            // newline that is the extra separator is skipped here.
            if ((c == CHAR_NUL) || (is_eol(c) && !is_sep(c, extra_sep))) begin
               nres    = 2'd1;
               mode_in = MODE_BETWEEN;
               cnt_in  = '0;
            end else if (is_sep(c, extra_sep)) begin
               nres = 2'd0;
            end else if (cnt_ff >= CNT_MAX) begin
               mode_in = MODE_DISCARD;
            end else begin
               cnt_in = cnt_ff + CW'(1);
               if (is_quote(c)) begin
                  mode_in = MODE_QUOTED;
               end else begin
                  mode_in            = MODE_TOKEN;
                  nres               = 2'd1;
                  item0.kind         = KIND_CHAR;
                  item0.payload      = c;
                  item0.token_number = cnt_ext[4:0];
                  item0.last         = 1'b1;
               end
            end
         end
         MODE_TOKEN, MODE_QUOTED: begin
            if (is_eol(c)) begin
               nres               = 2'd2;
               item0.kind         = KIND_END;
               item0.payload      = 8'd0;
               item0.token_number = cur_ext[4:0];
               item0.last         = 1'b0;
               mode_in            = MODE_BETWEEN;
               cnt_in             = '0;
            end else if ((mode_ff == MODE_TOKEN) && is_sep(c, extra_sep)) begin
               nres               = 2'd1;
               item0.kind         = KIND_END;
               item0.payload      = 8'd0;
               item0.token_number = cur_ext[4:0];
               item0.last         = 1'b1;
               mode_in            = MODE_BETWEEN;
            end else if (is_quote(c)) begin
               mode_in = (mode_ff == MODE_TOKEN) ? MODE_QUOTED : MODE_TOKEN;
            end else begin
               nres               = 2'd1;
               item0.kind         = KIND_CHAR;
               item0.payload      = c;
               item0.token_number = cur_ext[4:0];
               item0.last         = 1'b1;
            end
         end
         MODE_DISCARD: begin
            if (is_eol(c)) begin
               nres    = 2'd1;
               mode_in = MODE_BETWEEN;
               cnt_in  = '0;
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
         mode_ff     <= MODE_BETWEEN;
         cnt_ff      <= '0;
      end else begin
         in_valid_ff <= in_valid_in;
         if (fire) begin
            mode_ff <= mode_in;
            cnt_ff  <= cnt_in;
         end
      end
   end

   always_comb begin
      scan_out.count = fire ? nres : 2'd0;
      scan_out.item0 = item0;
      scan_out.item1 = item1;
   end

   `QFT_ASSERT_NOW(a_cnt_bound, 1'b1, cnt_ff <= CNT_MAX, "parameter count over limit")
   `QFT_ASSERT_NOW(a_discard_full, mode_ff == MODE_DISCARD, cnt_ff == CNT_MAX, "discard below limit")
   `QFT_ASSERT_NOW(a_open_has_cnt, mode_ff == MODE_TOKEN || mode_ff == MODE_QUOTED, cnt_ff != '0, "open parameter with zero count")
   `QFT_ASSERT_NEXT(a_line_clears, fire && mode_ff != MODE_BETWEEN && is_eol(c), cnt_ff == '0 && mode_ff == MODE_BETWEEN, "line end left state")

endmodule

`default_nettype wire

// ----- hdl/qft_rsp_fifo.sv -----
// ---------------------------------------------------------------------------
// qft_rsp_fifo
// Four-entry result queue taking up to two results per cycle, one out.
// ---------------------------------------------------------------------------
`default_nettype none

`include "quoted_field_tokenizer_top_defines.svh"

module qft_rsp_fifo import qft_pkg::*; (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire scan_out_type scan_out,
   output logic              room,
   output logic              rsp_valid,
   input  wire logic         rsp_ready,
   output rsp_item_type      rsp_item
);

   rsp_item_type entry_ff [4];
   logic [1:0]   wr_ff, wr_in;
   logic [1:0]   rd_ff, rd_in;
   logic [2:0]   count_ff, count_in;
   logic         pop;
   logic [1:0]   wr_next;

   assign room      = (count_ff <= 3'd2);
   assign rsp_valid = (count_ff != 3'd0);
   assign pop       = rsp_valid && rsp_ready;
   assign rsp_item  = entry_ff[rd_ff];
   assign wr_next   = wr_ff + 2'd1;

   always_comb begin
      wr_in    = wr_ff + scan_out.count;
      rd_in    = pop ? rd_ff + 2'd1 : rd_ff;
      count_in = count_ff + {1'b0, scan_out.count} - {2'd0, pop};
   end

   always_ff @(posedge clock) begin
      if (scan_out.count != 2'd0) begin
         entry_ff[wr_ff] <= scan_out.item0;
      end
      if (scan_out.count == 2'd2) begin
         entry_ff[wr_next] <= scan_out.item1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff    <= 2'd0;
         rd_ff    <= 2'd0;
         count_ff <= 3'd0;
      end else begin
         wr_ff    <= wr_in;
         rd_ff    <= rd_in;
         count_ff <= count_in;
      end
   end

   `QFT_ASSERT_NOW(a_count_bound, 1'b1, count_ff <= 3'd4, "result queue overfilled")
   `QFT_ASSERT_NOW(a_push_room, scan_out.count != 2'd0, room, "push without room")
   `QFT_ASSERT_NEXT(a_pop_drains, pop && scan_out.count == 2'd0, count_ff == $past(count_ff) - 3'd1, "pop did not drain")

endmodule

`default_nettype wire

// ----- hdl/quoted_field_tokenizer_top.sv -----
// ---------------------------------------------------------------------------
// quoted_field_tokenizer_top
// Splits a character stream into quoted-aware parameters, one character in.
// ---------------------------------------------------------------------------
//   Port group  Direction  Carries
//   req_*       in         one text character per item
//   rsp_*       out        kind, payload, token number, last flag per item
//   csr_*       in/out     extra separator register, APB-style
//
// A character is taken every cycle while the result queue has room; its results are
// written to the queue, which drives rsp_valid. A newline or NUL inside a parameter
// gives two results, which the single output port hands out in turn; the four-entry
// result queue sets when input stalls (it needs room for two results to retire an
// item). Reset clears the mode, the parameter count and the queue, and sets the
// extra separator to a space. rsp_ready low fills the queue and stalls input.
// ---------------------------------------------------------------------------
`default_nettype none

module quoted_field_tokenizer_top import qft_pkg::*; #(
   parameter int MAX_PARAMS = 32
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_ready,
   input  wire logic [7:0]            req_text_char,
   output logic                       rsp_valid,
   input  wire logic                  rsp_ready,
   output logic      [1:0]            rsp_kind,
   output logic      [7:0]            rsp_payload,
   output logic      [4:0]            rsp_token_number,
   output logic                       rsp_last,
   input  wire logic                  csr_psel,
   input  wire logic                  csr_penable,
   input  wire logic                  csr_pwrite,
   input  wire logic [CSR_ADDR_W-1:0] csr_paddr,
   input  wire logic [31:0]           csr_pwdata,
   output logic      [31:0]           csr_prdata,
   output logic                       csr_pready
);

   logic         [7:0] extra_sep;
   logic               room;
   scan_out_type       scan_out;
   rsp_item_type       rsp_item;

   qft_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .extra_sep   (extra_sep)
   );

   qft_scan #(.MAX_PARAMS(MAX_PARAMS)) u_scan (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_text_char (req_text_char),
      .extra_sep     (extra_sep),
      .room          (room),
      .scan_out      (scan_out)
   );

   qft_rsp_fifo u_rsp_fifo (
      .clock     (clock),
      .reset     (reset),
      .scan_out  (scan_out),
      .room      (room),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_item  (rsp_item)
   );

   assign rsp_kind         = rsp_item.kind;
   assign rsp_payload      = rsp_item.payload;
   assign rsp_token_number = rsp_item.token_number;
   assign rsp_last         = rsp_item.last;

endmodule

`default_nettype wire
